// ----- hdl/wso_pkg.sv -----
package wso_pkg;

  // Wavetable storage and CORDIC sizing
  localparam int unsigned TableDepth  = 8192;
  localparam int unsigned TabAw       = $clog2(TableDepth);
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned CntW        = $clog2(CordicSteps);

  // Sine datapath constants
  localparam logic [31:0]        OneRadTurns   = 32'd683565276;
  localparam logic signed [33:0] CordicGainQ30 = 34'sd652032874;
  localparam logic signed [33:0] QOne          = 34'sd1073741824;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgMode  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgInc   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPer   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgTurn  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRef   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgGain  = 3'd5;

  // Register reset values
  localparam logic [1:0]  RstMode = 2'd0;
  localparam logic [28:0] RstInc  = 29'd65536;
  localparam logic [12:0] RstPer  = 13'd5872;
  localparam logic [31:0] RstTurn = 32'd731432;
  localparam logic [15:0] RstRef  = 16'd4095;
  localparam logic [15:0] RstGain = 16'd16384;

  // Waveform modes
  localparam logic [1:0] ModeTable  = 2'd0;
  localparam logic [1:0] ModeSine   = 2'd1;
  localparam logic [1:0] ModeSquare = 2'd2;

  // Commands
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdTick = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TABLE_RD,
    ST_SIN_MUL,
    ST_SIN_LVL,
    ST_SIN_CORD,
    ST_SIN_SCALE,
    ST_FINISH
  } state_e;

  // arctan(2^-i) in Q0.32 turns
  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:    r = 32'd536870912;
      5'd1:    r = 32'd316933406;
      5'd2:    r = 32'd167458907;
      5'd3:    r = 32'd85004756;
      5'd4:    r = 32'd42667331;
      5'd5:    r = 32'd21354465;
      5'd6:    r = 32'd10679838;
      5'd7:    r = 32'd5340245;
      5'd8:    r = 32'd2670163;
      5'd9:    r = 32'd1335087;
      5'd10:   r = 32'd667544;
      5'd11:   r = 32'd333772;
      5'd12:   r = 32'd166886;
      5'd13:   r = 32'd83443;
      5'd14:   r = 32'd41722;
      5'd15:   r = 32'd20861;
      5'd16:   r = 32'd10430;
      5'd17:   r = 32'd5215;
      5'd18:   r = 32'd2608;
      5'd19:   r = 32'd1304;
      5'd20:   r = 32'd652;
      5'd21:   r = 32'd326;
      5'd22:   r = 32'd163;
      5'd23:   r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/wso_table_ram.sv -----
module wso_table_ram #(
  parameter int unsigned Depth = 8192,
  parameter int unsigned Width = 16,
  localparam int unsigned Aw = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/wso_mul.sv -----
module wso_mul import wso_pkg::*; (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

// ----- hdl/wso_cordic.sv -----
module wso_cordic import wso_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] angle_i,
  output logic        done_o,
  output logic [31:0] level_o
);

  logic                   busy_q, busy_d;
  logic                   fin_q, fin_d;
  logic                   done_q, done_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic signed [33:0]     x_q, x_d, y_q, y_d, z_q, z_d;
  logic [31:0]            level_q, level_d;
  logic [31:0]            folded;
  logic [1:0]             quad;
  logic signed [33:0]     xs, ys, at, y_c, u;

  assign quad   = angle_i[31:30];
  assign folded = (quad == 2'd1 || quad == 2'd2) ? 32'h8000_0000 - angle_i : angle_i;

  assign xs = x_q >>> cnt_q;
  assign ys = y_q >>> cnt_q;
  assign at = $signed({2'b00, atan_turns(5'(cnt_q))});

  always_comb begin
    if (y_q > QOne) begin
      y_c = QOne;
    end else if (y_q < -QOne) begin
      y_c = -QOne;
    end else begin
      y_c = y_q;
    end
    u = y_c + QOne;
  end

  always_comb begin
    busy_d  = busy_q;
    fin_d   = 1'b0;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    level_d = level_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      x_d    = CordicGainQ30;
      y_d    = '0;
      z_d    = $signed({{2{folded[31]}}, folded});
    end else if (busy_q) begin
      // rotate toward zero residual angle
      if (!z_q[33]) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - at;
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + at;
      end
      if (cnt_q == CntW'(CordicSteps - 1)) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end else if (fin_q) begin
      level_d = u[31:0];
      done_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    z_q     <= z_d;
    level_q <= level_d;
  end

  assign done_o  = done_q;
  assign level_o = level_q;

endmodule

// ----- hdl/wavetable_sine_square_oscillator_unit.sv -----
// Channel   Direction  Fields (low bit up)
// s_axis    in         tuser: command; tdata: table_address[12:0], table_word[28:13]
// m_axis    out        tdata: sample[15:0]
// cfg       in         write only: cfg_idx_i selects register, cfg_data_i holds value
//
// Load beat: written straight into the wavetable RAM.
// Table tick: RAM read, then output load. Square tick: level computed on acceptance, then output load.
// Sine tick: runs through the iterative CORDIC (one rotation a cycle)
// and the shared 32x32 multiplier used three times in sequence.
// A finished sample waits in the output register; the next beat is taken meanwhile and
// holds in its last state only while the previous sample is still untaken.
// Reset clears control and phase index and restores configuration defaults; the wavetable is not cleared.
module wavetable_sine_square_oscillator_unit import wso_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,   // table_address[12:0], table_word[28:13]
  input  logic               s_axis_tuser,   // command[0]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata,   // sample[15:0]
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_data_i
);

  state_e state_q, state_d;

  logic [1:0]  mode_q;
  logic [28:0] inc_q;
  logic [12:0] per_q;
  logic [31:0] turn_q;
  logic [15:0] ref_q;
  logic [15:0] gain_q;

  logic [28:0] index_q, index_d;
  logic [15:0] res_q, res_d;
  logic [31:0] lvl_q, lvl_d;
  logic        ovalid_q, ovalid_d;
  logic [15:0] odata_q, odata_d;

  logic        accept, is_tick;
  logic [12:0] in_addr;
  logic [15:0] in_word;
  logic [31:0] waddr_full, raddr_full;
  logic [29:0] rnd, step1, stepinc, per_ext;
  logic [31:0] sq_level;
  logic        sq_high;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic        cord_start, cord_done;
  logic [31:0] cord_level;
  logic [15:0] ram_rdata;
  logic        ram_we, ram_re;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept  = s_axis_tvalid & s_axis_tready;
  assign is_tick = (s_axis_tuser == CmdTick);
  assign in_addr = s_axis_tdata[12:0];
  assign in_word = s_axis_tdata[28:13];

  // table address = rounded index, wrapped to table depth
  assign rnd        = {1'b0, index_q} + 30'd32768;
  assign raddr_full = 32'(rnd[29:16]);
  assign waddr_full = 32'(in_addr);

  assign per_ext  = {1'b0, per_q, 16'd0};
  assign step1    = {1'b0, index_q} + 30'd65536;
  assign stepinc  = {1'b0, index_q} + {1'b0, inc_q};
  assign sq_level = 32'(ref_q) * 32'(gain_q);
  assign sq_high  = ({index_q, 1'b0} > per_ext);

  assign ram_we = accept && (s_axis_tuser == CmdLoad);
  assign ram_re = accept && is_tick && mode_q != ModeSine && mode_q != ModeSquare;

  wso_table_ram #(
    .Depth(TableDepth),
    .Width(16)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr_full[TabAw-1:0]),
    .wdata_i (in_word),
    .re_i    (ram_re),
    .raddr_i (raddr_full[TabAw-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    case (state_q)
      ST_SIN_MUL: begin
        mul_a = 32'(ref_q);
        mul_b = 32'(gain_q);
      end
      ST_SIN_CORD: begin
        mul_a = lvl_q;
        mul_b = cord_level;
      end
      default: begin
        mul_a = 32'(index_q);
        mul_b = turn_q;
      end
    endcase
  end

  wso_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign cord_start = (state_q == ST_SIN_MUL);

  wso_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .angle_i (prod[47:16] + OneRadTurns),
    .done_o  (cord_done),
    .level_o (cord_level)
  );

  always_comb begin
    state_d  = state_q;
    index_d  = index_q;
    res_d    = res_q;
    lvl_d    = lvl_q;
    ovalid_d = ovalid_q;
    odata_d  = odata_q;

    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept && is_tick) begin
          if (mode_q == ModeSine || mode_q == ModeSquare) begin
            index_d = (step1 > per_ext) ? '0 : step1[28:0];
            if (mode_q == ModeSine) begin
              state_d = ST_SIN_MUL;
            end else begin
              if (!sq_high) begin
                res_d = '0;
              end else if (sq_level[31:30] != 2'b00) begin
                res_d = 16'hFFFF;
              end else begin
                res_d = sq_level[29:14];
              end
              state_d = ST_FINISH;
            end
          end else begin
            index_d = (stepinc >= per_ext) ? '0 : stepinc[28:0];
            state_d = ST_TABLE_RD;
          end
        end
      end
      ST_TABLE_RD: begin
        res_d   = ram_rdata;
        state_d = ST_FINISH;
      end
      ST_SIN_MUL: begin
        state_d = ST_SIN_LVL;
      end
      ST_SIN_LVL: begin
        lvl_d   = prod[31:0];
        state_d = ST_SIN_CORD;
      end
      ST_SIN_CORD: begin
        if (cord_done) begin
          state_d = ST_SIN_SCALE;
        end
      end
      ST_SIN_SCALE: begin
        res_d   = (prod[63:61] != 3'b000) ? 16'hFFFF : prod[60:45];
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          odata_d  = res_q;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      index_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      index_q  <= index_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    lvl_q   <= lvl_d;
    odata_q <= odata_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= RstMode;
      inc_q  <= RstInc;
      per_q  <= RstPer;
      turn_q <= RstTurn;
      ref_q  <= RstRef;
      gain_q <= RstGain;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMode: mode_q <= cfg_data_i[1:0];
        CfgInc:  inc_q  <= cfg_data_i[28:0];
        CfgPer:  per_q  <= cfg_data_i[12:0];
        CfgTurn: turn_q <= cfg_data_i;
        CfgRef:  ref_q  <= cfg_data_i[15:0];
        CfgGain: gain_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

endmodule
